/* rtl/tcw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg
// shared types and constants of the text console writer
// ----------------------------------------------------------------------------
package tcw_pkg;

	localparam int DEF_COLUMNS = 80;
	localparam int DEF_ROWS    = 25;

	// fixed widths of the item fields
	localparam int POS_W  = 11;
	localparam int CELL_W = 16;

	localparam logic [7:0]        NEWLINE_CODE = 8'd10;
	localparam logic [CELL_W-1:0] BLANK_RESET  = 16'h0F00;

	localparam logic MODE_PUT  = 1'b0;
	localparam logic MODE_READ = 1'b1;

	typedef struct packed {
		logic             mode;
		logic [7:0]       char_code;
		logic [7:0]       attribute;
		logic [POS_W-1:0] cell_index;
	} cmd_t;

	typedef struct packed {
		logic [CELL_W-1:0] cell_value;
		logic [POS_W-1:0]  cursor_position;
		logic              scrolled;
	} result_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_COPY,
		ST_FILL
	} state_t;

	// status and memory strobes from the sequencer
	typedef struct packed {
		logic busy;
		logic wr_en;
		logic rd_en;
	} seq_status_t;

endpackage

/* rtl/tcw_cell_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_cell_ram
// screen cell store: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module tcw_cell_ram #(
	parameter int DEPTH = tcw_pkg::DEF_ROWS * tcw_pkg::DEF_COLUMNS
) (
	input  logic                        clk,
	input  logic                        wr_en,
	input  logic [$clog2(DEPTH)-1:0]    wr_addr,
	input  logic [tcw_pkg::CELL_W-1:0]  wr_data,
	input  logic                        rd_en,
	input  logic [$clog2(DEPTH)-1:0]    rd_addr,
	output logic [tcw_pkg::CELL_W-1:0]  rd_data
);

	logic [tcw_pkg::CELL_W-1:0] mem [DEPTH];
	logic [tcw_pkg::CELL_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* rtl/tcw_seq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_seq
// memory sweeps: clearing pass after reset, row copy and bottom-row fill
// ----------------------------------------------------------------------------
module tcw_seq #(
	parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
	parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       scroll_start,
	input  logic [tcw_pkg::CELL_W-1:0]                 blank_cell,
	input  logic [tcw_pkg::CELL_W-1:0]                 rd_data,
	output tcw_pkg::seq_status_t                       status,
	output logic [$clog2(ROWS*COLUMNS)-1:0]            wr_addr,
	output logic [tcw_pkg::CELL_W-1:0]                 wr_data,
	output logic [$clog2(ROWS*COLUMNS)-1:0]            rd_addr
);

	localparam int CELL_COUNT = ROWS * COLUMNS;
	localparam int COPY_COUNT = (ROWS - 1) * COLUMNS;
	localparam int ADDR_W     = $clog2(CELL_COUNT);

	tcw_pkg::state_t   state_q, state_d;
	logic [ADDR_W-1:0] cnt_q, cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tcw_pkg::ST_CLEAR;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		cnt_d        = cnt_q;
		status.busy  = 1'b1;
		status.wr_en = 1'b0;
		status.rd_en = 1'b0;
		wr_addr      = cnt_q;
		wr_data      = blank_cell;
		rd_addr      = ADDR_W'(cnt_q + ADDR_W'(COLUMNS));
		case (state_q)
			tcw_pkg::ST_CLEAR: begin
				status.wr_en = 1'b1;
				wr_data      = tcw_pkg::BLANK_RESET;
				if (cnt_q == ADDR_W'(CELL_COUNT - 1)) begin
					state_d = tcw_pkg::ST_IDLE;
					cnt_d   = '0;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			tcw_pkg::ST_IDLE: begin
				status.busy = 1'b0;
				if (scroll_start) begin
					state_d = tcw_pkg::ST_COPY;
					cnt_d   = '0;
				end
			end
			tcw_pkg::ST_COPY: begin
				// read one row below, write the cell read in the cycle before
				status.rd_en = (cnt_q != ADDR_W'(COPY_COUNT));
				status.wr_en = (cnt_q != '0);
				wr_addr      = cnt_q - 1'b1;
				wr_data      = rd_data;
				if (cnt_q == ADDR_W'(COPY_COUNT)) begin
					state_d = tcw_pkg::ST_FILL;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			tcw_pkg::ST_FILL: begin
				status.wr_en = 1'b1;
				if (cnt_q == ADDR_W'(CELL_COUNT - 1)) begin
					state_d = tcw_pkg::ST_IDLE;
					cnt_d   = '0;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			default: begin
				state_d = tcw_pkg::ST_IDLE;
				cnt_d   = '0;
			end
		endcase
	end

endmodule

/* rtl/text_console_writer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer
// text-mode console: cell store with cursor, scrolling and cell read-out
// ----------------------------------------------------------------------------
// usage:
//   an item (cmd) is taken at a clock edge with start high and busy low.
//   mode put writes {attribute, char_code} at the cursor (newline moves to
//   the next row), mode read fetches the cell at cell_index from the store.
//   each item gives one result on result, shown for one cycle with done high,
//   the cycle after the item is taken; the receiver cannot stall it.
//   throughput: one item a cycle while no scroll occurs; a put that scrolls
//   holds busy high while the sequencer moves the rows up through the single
//   cell memory port pair and fills the bottom row with blank_cell.
//   reset: busy stays high while the clearing pass writes the reset blank
//   cell into every entry; the cursor returns to 0.
//   cfg: blank_cell is written on cfg_valid with cfg_ready (always high).
// ----------------------------------------------------------------------------
module text_console_writer #(
	parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
	parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  tcw_pkg::cmd_t               cmd,
	output logic                        done,
	output tcw_pkg::result_t            result,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [tcw_pkg::CELL_W-1:0]  cfg_data
);

	localparam int CELL_COUNT = ROWS * COLUMNS;
	localparam int COPY_COUNT = (ROWS - 1) * COLUMNS;
	localparam int ADDR_W     = $clog2(CELL_COUNT);
	localparam int COL_W      = $clog2(COLUMNS);
	localparam int ROW_W      = $clog2(ROWS);

	tcw_pkg::seq_status_t       seq_status;
	logic [ADDR_W-1:0]          seq_wr_addr, seq_rd_addr;
	logic [tcw_pkg::CELL_W-1:0] seq_wr_data;

	logic                       ram_wr_en, ram_rd_en;
	logic [ADDR_W-1:0]          ram_wr_addr, ram_rd_addr;
	logic [tcw_pkg::CELL_W-1:0] ram_wr_data, ram_rd_data;

	logic [tcw_pkg::CELL_W-1:0] blank_q;
	logic [COL_W-1:0]           col_q, col_d;
	logic [ROW_W-1:0]           row_q, row_d;
	logic [ADDR_W-1:0]          pos_q, pos_d;

	logic accept, put, is_nl, wrap_row, last_row, scroll, in_range;

	logic                         res_valid_s1;
	logic                         res_read_s1;
	logic [tcw_pkg::POS_W-1:0]    res_pos_s1;
	logic                         res_scroll_s1;

	assign busy      = seq_status.busy;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;
	assign put       = accept && (cmd.mode == tcw_pkg::MODE_PUT);
	assign is_nl     = (cmd.char_code == tcw_pkg::NEWLINE_CODE);
	assign last_row  = (row_q == ROW_W'(ROWS - 1));
	assign wrap_row  = is_nl || (col_q == COL_W'(COLUMNS - 1));
	assign scroll    = put && wrap_row && last_row;
	assign in_range  = (32'(cmd.cell_index) < CELL_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blank_q <= tcw_pkg::BLANK_RESET;
		end else if (cfg_valid && cfg_ready) begin
			blank_q <= cfg_data;
		end
	end

	// cursor step; pos tracks row*COLUMNS+col without a multiplier
	always_comb begin
		col_d = col_q;
		row_d = row_q;
		pos_d = pos_q;
		if (put) begin
			if (wrap_row && last_row) begin
				col_d = '0;
				pos_d = ADDR_W'(COPY_COUNT);
			end else if (wrap_row) begin
				col_d = '0;
				row_d = row_q + 1'b1;
				pos_d = is_nl ? ADDR_W'(pos_q - ADDR_W'(col_q) + ADDR_W'(COLUMNS))
				              : ADDR_W'(pos_q + 1'b1);
			end else begin
				col_d = col_q + 1'b1;
				pos_d = pos_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q        <= '0;
			row_q        <= '0;
			pos_q        <= '0;
			res_valid_s1 <= 1'b0;
		end else begin
			col_q        <= col_d;
			row_q        <= row_d;
			pos_q        <= pos_d;
			res_valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_read_s1   <= (cmd.mode == tcw_pkg::MODE_READ) && in_range;
			res_pos_s1    <= tcw_pkg::POS_W'(pos_d);
			res_scroll_s1 <= scroll;
		end
	end

	// sequencer owns the ports while busy, so no item access collides with it
	always_comb begin
		if (seq_status.wr_en) begin
			ram_wr_en   = 1'b1;
			ram_wr_addr = seq_wr_addr;
			ram_wr_data = seq_wr_data;
		end else begin
			ram_wr_en   = put && !is_nl;
			ram_wr_addr = pos_q;
			ram_wr_data = {cmd.attribute, cmd.char_code};
		end
		if (seq_status.rd_en) begin
			ram_rd_en   = 1'b1;
			ram_rd_addr = seq_rd_addr;
		end else begin
			ram_rd_en   = accept && (cmd.mode == tcw_pkg::MODE_READ) && in_range;
			ram_rd_addr = ADDR_W'(cmd.cell_index);
		end
	end

	tcw_seq #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.scroll_start (scroll),
		.blank_cell   (blank_q),
		.rd_data      (ram_rd_data),
		.status       (seq_status),
		.wr_addr      (seq_wr_addr),
		.wr_data      (seq_wr_data),
		.rd_addr      (seq_rd_addr)
	);

	tcw_cell_ram #(
		.DEPTH (CELL_COUNT)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	assign done                   = res_valid_s1;
	assign result.cell_value      = res_read_s1 ? ram_rd_data : '0;
	assign result.cursor_position = res_pos_s1;
	assign result.scrolled        = res_scroll_s1;

endmodule

/* tb/text_console_writer_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer_checker
// watches the item, result and blank-cell channels of the console writer,
// keeps its own copy of the screen and cursor, and compares every result
// with the oldest predicted report
// ----------------------------------------------------------------------------
module text_console_writer_checker
	import tcw_pkg::*;
#(
	parameter int COLUMNS = DEF_COLUMNS,
	parameter int ROWS    = DEF_ROWS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  cmd_t              cmd,
	input  logic              done,
	input  result_t           result,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [CELL_W-1:0] cfg_data,
	output int                fail_count,
	output int                outstanding,
	output int                scroll_count
);

	localparam int CELLS = ROWS * COLUMNS;

	logic [CELL_W-1:0] screen [0:CELLS-1];
	logic [CELL_W-1:0] blank_value;
	int                cursor_col;
	int                cursor_row;
	result_t           cursor_reports [$];
	result_t           oldest;

	// applies one item to the screen copy and returns the report it causes
	function automatic result_t advance_console(cmd_t item);
		result_t rep;
		int      addr;
		int      i;
		rep = '0;
		if (item.mode == MODE_READ) begin
			if (int'(item.cell_index) < CELLS)
				rep.cell_value = screen[item.cell_index];
		end else begin
			if (item.char_code == NEWLINE_CODE) begin
				cursor_row++;
				cursor_col = 0;
			end else begin
				addr = cursor_row * COLUMNS + cursor_col;
				if (addr < CELLS)
					screen[addr] = {item.attribute, item.char_code};
				cursor_col++;
			end
			if (cursor_col >= COLUMNS) begin
				cursor_col = 0;
				cursor_row++;
			end
			if (cursor_row >= ROWS) begin
				cursor_row = ROWS - 1;
				for (i = 0; i < (ROWS - 1) * COLUMNS; i++)
					screen[i] = screen[i + COLUMNS];
				for (i = (ROWS - 1) * COLUMNS; i < CELLS; i++)
					screen[i] = blank_value;
				rep.scrolled = 1'b1;
				scroll_count++;
			end
		end
		rep.cursor_position = POS_W'(cursor_row * COLUMNS + cursor_col);
		return rep;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CELLS; i++)
				screen[i] = BLANK_RESET;
			blank_value = BLANK_RESET;
			cursor_col = 0;
			cursor_row = 0;
			cursor_reports.delete();
			fail_count = 0;
			scroll_count = 0;
			outstanding <= 0;
		end else begin
			// a result is checked before the item taken at this edge is queued
			if (done) begin
				if (cursor_reports.size() == 0) begin
					if (fail_count < 10)
						$display("%0t: result with nothing pending: cell %h pos %0d scrolled %b",
							$realtime, result.cell_value, result.cursor_position,
							result.scrolled);
					fail_count++;
				end else begin
					oldest = cursor_reports.pop_front();
					if (result.cell_value !== oldest.cell_value ||
							result.cursor_position !== oldest.cursor_position ||
							result.scrolled !== oldest.scrolled) begin
						if (fail_count < 10)
							$display("%0t: mismatch: expected cell %h pos %0d scrolled %b, got cell %h pos %0d scrolled %b",
								$realtime, oldest.cell_value, oldest.cursor_position,
								oldest.scrolled, result.cell_value,
								result.cursor_position, result.scrolled);
						fail_count++;
					end
				end
			end
			if (cfg_valid && cfg_ready)
				blank_value = cfg_data;
			if (start && !busy)
				cursor_reports.push_back(advance_console(cmd));
			outstanding <= cursor_reports.size();
		end
	end

endmodule

/* tb/text_console_writer_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer_tb
// drives put, newline and read items into the console writer with directed
// edge cases, then random traffic over several blank-cell settings and
// sender idle rates; the checker beside the block predicts every result
// ----------------------------------------------------------------------------
module text_console_writer_tb;
	import tcw_pkg::*;

	// any put may scroll, and a scroll holds busy while the rows are moved up
	localparam int LIMIT        = 10000000;
	localparam int PHASE_ITEMS  = 320;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	cmd_t              cmd;
	logic              done;
	result_t           result;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [CELL_W-1:0] cfg_data;

	int fail_count;
	int outstanding;
	int scroll_count;
	int cycle_count;

	int put_items;
	int newline_items;
	int read_items;
	int blank_writes;
	int phase;
	int n;
	int idle_pct [4] = '{0, 54, 21, 54};
	logic [CELL_W-1:0] blank_setting;

	text_console_writer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	text_console_writer_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.cmd          (cmd),
		.done         (done),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.fail_count   (fail_count),
		.outstanding  (outstanding),
		.scroll_count (scroll_count)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("text_console_writer test failed");
		$finish;
	end

	function automatic cmd_t make_cmd(logic m, logic [7:0] code, logic [7:0] attr,
			logic [POS_W-1:0] idx);
		cmd_t c;
		c.mode       = m;
		c.char_code  = code;
		c.attribute  = attr;
		c.cell_index = idx;
		return c;
	endfunction

	function automatic cmd_t random_item();
		cmd_t c;
		int   r;
		c = make_cmd(MODE_PUT, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			POS_W'($urandom_range(0, 2047)));
		r = $urandom_range(0, 99);
		if (r < 40) begin
			c.mode = MODE_READ;
			// half the reads land on the lower rows where text ends up
			if ($urandom_range(0, 1))
				c.cell_index = POS_W'($urandom_range(1600, 1999));
		end else if (r < 45) begin
			c.char_code = NEWLINE_CODE;
		end
		return c;
	endfunction

	// item held on cmd until taken; an optional gap with start low first
	task automatic send_item(input cmd_t item, input int idle);
		if ($urandom_range(0, 99) < idle) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < idle);
		end
		start <= 1'b1;
		cmd   <= item;
		do @(posedge clk); while (busy);
		if (item.mode == MODE_READ)
			read_items++;
		else if (item.char_code == NEWLINE_CODE)
			newline_items++;
		else
			put_items++;
	endtask

	// holds off until every result is back and any scroll has finished
	task automatic wait_until_drained();
		start <= 1'b0;
		do @(posedge clk); while (outstanding != 0 || busy);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_blank(input logic [CELL_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		blank_writes++;
	endtask

	initial begin
		put_items     = 0;
		newline_items = 0;
		read_items    = 0;
		blank_writes  = 0;
		arst_n    <= 1'b0;
		start     <= 1'b0;
		cmd       <= '0;
		cfg_valid <= 1'b0;
		cfg_data  <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		// clearing pass after reset keeps busy high
		do @(posedge clk); while (busy);

		write_blank(16'h0000);

		// directed: read extremes, out-of-range reads, field extremes
		send_item(make_cmd(MODE_READ, 8'h00, 8'h00, 11'd0), 0);
		send_item(make_cmd(MODE_READ, 8'hFF, 8'hFF, 11'd1999), 0);
		send_item(make_cmd(MODE_READ, 8'h00, 8'h00, 11'd2000), 0);
		send_item(make_cmd(MODE_READ, 8'hFF, 8'hFF, 11'd2047), 0);
		send_item(make_cmd(MODE_PUT, 8'h00, 8'h00, 11'd2047), 0);
		send_item(make_cmd(MODE_PUT, 8'hFF, 8'hFF, 11'd0), 0);
		send_item(make_cmd(MODE_PUT, 8'd9, 8'h5A, 11'd0), 0);
		send_item(make_cmd(MODE_PUT, 8'd11, 8'hA5, 11'd0), 0);
		send_item(make_cmd(MODE_PUT, NEWLINE_CODE, 8'hFF, 11'd2047), 0);
		send_item(make_cmd(MODE_PUT, 8'h41, 8'h1F, 11'd0), 0);
		send_item(make_cmd(MODE_PUT, NEWLINE_CODE, 8'h00, 11'd0), 0);
		send_item(make_cmd(MODE_PUT, NEWLINE_CODE, 8'h00, 11'd0), 0);
		send_item(make_cmd(MODE_READ, 8'h00, 8'h00, 11'd0), 0);
		send_item(make_cmd(MODE_READ, 8'h00, 8'h00, 11'd1), 0);
		send_item(make_cmd(MODE_READ, 8'h00, 8'h00, 11'd3), 0);
		send_item(make_cmd(MODE_READ, 8'h00, 8'h00, 11'd4), 0);
		send_item(make_cmd(MODE_READ, 8'h00, 8'h00, 11'd80), 0);
		send_item(make_cmd(MODE_READ, 8'h00, 8'h00, 11'd81), 0);
		send_item(make_cmd(MODE_READ, 8'h00, 8'h00, 11'd1024), 0);

		for (phase = 0; phase < 4; phase++) begin
			wait_until_drained();
			case (phase)
				0:       blank_setting = 16'hFFFF;
				2:       blank_setting = BLANK_RESET;
				default: blank_setting = 16'($urandom);
			endcase
			write_blank(blank_setting);
			for (n = 0; n < PHASE_ITEMS; n++) begin
				send_item(random_item(), idle_pct[phase]);
				if ($urandom_range(0, 99) == 0)
					wait_until_drained();
			end
		end

		wait_until_drained();
		repeat (8) @(posedge clk);

		$display("%0d items: %0d character puts, %0d newlines, %0d cell reads",
			put_items + newline_items + read_items, put_items, newline_items, read_items);
		$display("%0d scrolls under %0d blank cell settings, sender idle from 0 to 54 percent",
			scroll_count, blank_writes);
		if (fail_count == 0 && outstanding == 0) begin
			$display("text_console_writer test passed");
		end else begin
			$display("text_console_writer test failed");
		end
		$finish;
	end

endmodule
